### rtl/core/tvmeu_pkg.sv
// Shared types, constants and opcode decoding for the teaching machine execute unit.
package tvmeu_pkg;

  localparam int unsigned MEM_BYTES = 65536;
  localparam int MEM_AW = $clog2(MEM_BYTES);
  localparam int NUM_REGS = 22;
  localparam int REG_AW = $clog2(NUM_REGS);
  localparam logic [32:0] MEM_LIMIT = 33'(MEM_BYTES);

  localparam logic [REG_AW-1:0] R_PC = REG_AW'(16);
  localparam logic [REG_AW-1:0] R_SL = REG_AW'(17);
  localparam logic [REG_AW-1:0] R_SB = REG_AW'(18);
  localparam logic [REG_AW-1:0] R_SP = REG_AW'(19);
  localparam logic [REG_AW-1:0] R_FP = REG_AW'(20);
  localparam logic [REG_AW-1:0] R_HP = REG_AW'(21);

  typedef logic [5:0] opcode_t;
  localparam opcode_t OP_JMP = 6'd0;
  localparam opcode_t OP_JMR = 6'd1;
  localparam opcode_t OP_BNZ = 6'd2;
  localparam opcode_t OP_BGT = 6'd3;
  localparam opcode_t OP_BLT = 6'd4;
  localparam opcode_t OP_BRZ = 6'd5;
  localparam opcode_t OP_MOV = 6'd6;
  localparam opcode_t OP_MOVI = 6'd7;
  localparam opcode_t OP_LDA = 6'd8;
  localparam opcode_t OP_STR = 6'd9;
  localparam opcode_t OP_LDR = 6'd10;
  localparam opcode_t OP_STB = 6'd11;
  localparam opcode_t OP_LDB = 6'd12;
  localparam opcode_t OP_ISTR = 6'd13;
  localparam opcode_t OP_ILDR = 6'd14;
  localparam opcode_t OP_ISTB = 6'd15;
  localparam opcode_t OP_ILDB = 6'd16;
  localparam opcode_t OP_ADD = 6'd17;
  localparam opcode_t OP_ADDI = 6'd18;
  localparam opcode_t OP_SUB = 6'd19;
  localparam opcode_t OP_SUBI = 6'd20;
  localparam opcode_t OP_MUL = 6'd21;
  localparam opcode_t OP_MULI = 6'd22;
  localparam opcode_t OP_DIV = 6'd23;
  localparam opcode_t OP_DIVI = 6'd24;
  localparam opcode_t OP_SDIV = 6'd25;
  localparam opcode_t OP_AND = 6'd26;
  localparam opcode_t OP_OR = 6'd27;
  localparam opcode_t OP_CMP = 6'd28;
  localparam opcode_t OP_CMPI = 6'd29;
  localparam opcode_t OP_ALCI = 6'd30;
  localparam opcode_t OP_ALLC = 6'd31;
  localparam opcode_t OP_IALLC = 6'd32;
  localparam opcode_t OP_PSHR = 6'd33;
  localparam opcode_t OP_PSHB = 6'd34;
  localparam opcode_t OP_POPR = 6'd35;
  localparam opcode_t OP_POPB = 6'd36;
  localparam opcode_t OP_CALL = 6'd37;
  localparam opcode_t OP_RET = 6'd38;
  localparam opcode_t OP_TRP = 6'd39;
  localparam opcode_t OP_INIT = 6'd40;
  localparam opcode_t OP_PRELOAD = 6'd41;

  typedef logic [2:0] fault_t;
  localparam fault_t F_OK = 3'd0;
  localparam fault_t F_ILLEGAL = 3'd1;
  localparam fault_t F_DIVZERO = 3'd2;
  localparam fault_t F_RANGE = 3'd3;
  localparam fault_t F_STACK = 3'd4;
  localparam fault_t F_HEAP = 3'd5;

  typedef enum logic [3:0] {
    CL_JUMP, CL_BRANCH, CL_ALU, CL_DIV, CL_LOAD, CL_STORE, CL_ALLOC, CL_PUSH,
    CL_POP, CL_RET, CL_TRAP, CL_INIT, CL_PRELOAD, CL_ILLEGAL
  } class_t;

  typedef enum logic [4:0] {
    DP_NONE, DP_LOAD, DP_INIT, DP_PRELOAD, DP_PC_INC, DP_RD_D, DP_RD_A, DP_RD_B,
    DP_JUMP, DP_ALU, DP_WR_DEST, DP_DIV_START, DP_DIV_STEP, DP_DIV_RES,
    DP_MEM_SETUP, DP_MEM_WR, DP_MEM_RA, DP_MEM_RD, DP_MEM_RES, DP_SP_DEC,
    DP_POP, DP_SP_INC, DP_RET, DP_ALLOC_IMM, DP_ALLOC_LINK, DP_ALLOC_BUMP,
    DP_TRAP, DP_FINISH
  } dp_op_t;

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_RD_D, S_RD_A, S_RD_B, S_EXEC, S_WB, S_WB_CHK, S_DIV,
    S_DIV_END, S_PUSH_CHK, S_MEM_GO, S_MEM_WR, S_MEM_RA, S_MEM_RD, S_MEM_POST,
    S_POP_SP, S_POP_CHK, S_RET_CHK, S_ALLOC, S_ALLOC_BUMP, S_ALLOC_CHK, S_FINISH
  } state_t;

  typedef struct packed {
    dp_op_t op;
    logic   fault_we;
    fault_t fault_val;
  } dp_cmd_t;

  typedef struct packed {
    class_t cls;
    fault_t pre_fault;
    logic   preload_ok;
    logic   taken;
    logic   div_zero;
    logic   div_last;
    logic   mem_ok;
    logic   mem_write;
    logic   direct;
    logic   cnt_last;
    logic   push_ok;
    logic   pop_ok;
    logic   sp_ok;
    logic   heap_full;
    logic   dest_is_sp;
    logic   sp_chk;
    logic   is_call;
    logic   is_alci;
  } dp_status_t;

  function automatic class_t op_class(input opcode_t op);
    class_t c;
    priority if (op <= OP_JMR) c = CL_JUMP;
    else if (op <= OP_BRZ) c = CL_BRANCH;
    else if (op <= OP_LDA) c = CL_ALU;
    else if (op == OP_STR || op == OP_STB || op == OP_ISTR || op == OP_ISTB) c = CL_STORE;
    else if (op <= OP_ILDB) c = CL_LOAD;
    else if (op <= OP_MULI) c = CL_ALU;
    else if (op <= OP_SDIV) c = CL_DIV;
    else if (op <= OP_CMPI) c = CL_ALU;
    else if (op <= OP_IALLC) c = CL_ALLOC;
    else if (op == OP_PSHR || op == OP_PSHB || op == OP_CALL) c = CL_PUSH;
    else if (op == OP_POPR || op == OP_POPB) c = CL_POP;
    else if (op == OP_RET) c = CL_RET;
    else if (op == OP_TRP) c = CL_TRAP;
    else if (op == OP_INIT) c = CL_INIT;
    else if (op == OP_PRELOAD) c = CL_PRELOAD;
    else c = CL_ILLEGAL;
    return c;
  endfunction

endpackage

### rtl/core/teaching_vm_execute_unit.sv
// Top level of the teaching machine execute unit: controller and datapath.
//
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_stall  | operation, dest_reg, src_reg_a, src_reg_b,
//          |           |                      | immediate, preload_data
//  out     | output    | out_valid / out_stall| fault, next_pc, trap_request, trap_code,
//          |           |                      | written_value
//  cfg     | input     | cfg_valid / cfg_ready| cfg_data (code_end)
//
// An instruction that faults on its operands holds the unit the shortest time, then come jumps and
// register arithmetic, then word memory accesses, and divides hold it longest.
// The single byte-wide memory port and the radix-2 divider make the last two the slowest.
// Reset is synchronous and clears the register file, code_end and the controller.
// A stalled result waits in the output register while the next transaction is taken.
module teaching_vm_execute_unit import tvmeu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [5:0]  operation,
  input  logic [7:0]  dest_reg,
  input  logic [7:0]  src_reg_a,
  input  logic [7:0]  src_reg_b,
  input  logic [31:0] immediate,
  input  logic [7:0]  preload_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  fault,
  output logic [31:0] next_pc,
  output logic        trap_request,
  output logic [31:0] trap_code,
  output logic [31:0] written_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  tvmeu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  tvmeu_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_data      (cfg_data),
    .operation     (operation),
    .dest_reg      (dest_reg),
    .src_reg_a     (src_reg_a),
    .src_reg_b     (src_reg_b),
    .immediate     (immediate),
    .preload_data  (preload_data),
    .fault         (fault),
    .next_pc       (next_pc),
    .trap_request  (trap_request),
    .trap_code     (trap_code),
    .written_value (written_value)
  );

endmodule

### rtl/core/tvmeu_dp.sv
// Datapath of the execute unit: register file, byte memory, ALU, divider and result register.
module tvmeu_dp import tvmeu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  dp_cmd_t     cmd,
  output dp_status_t  status,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  input  logic [5:0]  operation,
  input  logic [7:0]  dest_reg,
  input  logic [7:0]  src_reg_a,
  input  logic [7:0]  src_reg_b,
  input  logic [31:0] immediate,
  input  logic [7:0]  preload_data,
  output logic [2:0]  fault,
  output logic [31:0] next_pc,
  output logic        trap_request,
  output logic [31:0] trap_code,
  output logic [31:0] written_value
);

  logic [31:0] rf [NUM_REGS];
  logic [15:0] code_end;
  logic [7:0]  mem [MEM_BYTES];
  logic [7:0]  mem_q;

  opcode_t     op_q;
  logic [7:0]  d_q, a_q, b_q, pd_q;
  logic [31:0] imm_q, rd_v, ra_v, rb_v, res;
  fault_t      fault_q;
  logic [31:0] wv_q;
  logic        trap_q;
  logic [31:0] maddr, mdata;
  logic        mword;
  logic [1:0]  mcnt;
  logic [31:0] rem, quo, dvs;
  logic [4:0]  dcnt;
  logic        dneg;

  logic [31:0] sp, sl, sb, hp, mul_b, div_a, div_b, sz32, mem_wdata, mem_addr_sel;
  logic [32:0] sz33, rem_shift;
  logic        byte_op, div_signed, word_sel;
  logic [MEM_AW-1:0] byte_addr;

  function automatic logic [2:0] reg_needs(input opcode_t op);
    logic [2:0] n;
    unique case (op)
      OP_JMP, OP_CALL, OP_RET, OP_TRP: n = 3'd0;
      OP_MOV, OP_ISTR, OP_ILDR, OP_ISTB, OP_ILDB, OP_ADDI, OP_SUBI, OP_MULI, OP_DIVI,
      OP_CMPI, OP_IALLC: n = 3'd3;
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_SDIV, OP_AND, OP_OR, OP_CMP: n = 3'd7;
      default: n = 3'd1;
    endcase
    return n;
  endfunction

  function automatic fault_t validate(input opcode_t op, input logic [7:0] d,
                                      input logic [7:0] a, input logic [7:0] b,
                                      input logic [31:0] imm);
    logic [2:0] need;
    logic       imm_out, word_out;
    fault_t     f;
    need = reg_needs(op);
    imm_out = {1'b0, imm} >= MEM_LIMIT;
    word_out = ({1'b0, imm} + 33'd3) >= MEM_LIMIT;
    priority if (op > OP_PRELOAD) f = F_ILLEGAL;
    else if (op >= OP_INIT) f = F_OK;
    else if (op == OP_DIVI && imm == 32'd0) f = F_DIVZERO;
    else if ((need[0] && d >= 8'(NUM_REGS)) || (need[1] && a >= 8'(NUM_REGS)) ||
             (need[2] && b >= 8'(NUM_REGS))) f = F_ILLEGAL;
    else if ((op <= OP_BRZ && op != OP_JMR && imm_out) || (op == OP_CALL && imm_out) ||
             (op == OP_ALCI && word_out)) f = F_RANGE;
    else f = F_OK;
    return f;
  endfunction

  function automatic logic [31:0] cmp3(input logic [31:0] x, input logic [31:0] y);
    logic [31:0] r;
    priority if (x == y) r = 32'd0;
    else if ($signed(x) > $signed(y)) r = 32'd1;
    else r = 32'hFFFF_FFFF;
    return r;
  endfunction

  always_comb begin
    sp = rf[R_SP];
    sl = rf[R_SL];
    sb = rf[R_SB];
    hp = rf[R_HP];
    byte_op = (op_q == OP_PSHB) || (op_q == OP_POPB);
    sz32 = byte_op ? 32'd1 : 32'd4;
    sz33 = {1'b0, sz32};
    mul_b = (op_q == OP_MULI) ? imm_q : rb_v;
    div_signed = (op_q != OP_DIV);
    div_a = ra_v;
    div_b = (op_q == OP_DIVI) ? imm_q : rb_v;
    rem_shift = {rem, quo[31]};
    byte_addr = maddr[MEM_AW-1:0] + MEM_AW'(mcnt);
    word_sel = !(byte_op || op_q == OP_STB || op_q == OP_LDB || op_q == OP_ISTB ||
                 op_q == OP_ILDB);
    if (op_q == OP_STR || op_q == OP_LDR || op_q == OP_STB || op_q == OP_LDB ||
        op_q == OP_ALLC) begin
      mem_addr_sel = imm_q;
    end else if (op_q >= OP_PSHR) begin
      mem_addr_sel = sp;
    end else begin
      mem_addr_sel = ra_v;
    end
    if (op_q == OP_CALL) begin
      mem_wdata = rf[R_PC];
    end else if ((op_q == OP_PSHR || op_q == OP_PSHB) && d_q == 8'(R_SP)) begin
      mem_wdata = sp;
    end else begin
      mem_wdata = rd_v;
    end

    status.cls = op_class(op_q);
    status.pre_fault = validate(op_q, d_q, a_q, b_q, imm_q);
    status.preload_ok = {1'b0, imm_q} < MEM_LIMIT;
    unique case (op_q)
      OP_BNZ: status.taken = rd_v != 32'd0;
      OP_BGT: status.taken = rd_v != 32'd0 && !rd_v[31];
      OP_BLT: status.taken = rd_v[31];
      default: status.taken = rd_v == 32'd0;
    endcase
    status.div_zero = (op_q != OP_DIVI) && rb_v == 32'd0;
    status.div_last = &dcnt;
    status.mem_ok = mword ? (({1'b0, maddr} + 33'd3) < MEM_LIMIT) : ({1'b0, maddr} < MEM_LIMIT);
    status.mem_write = (status.cls == CL_STORE) || (status.cls == CL_PUSH);
    status.direct = op_q == OP_STR || op_q == OP_LDR || op_q == OP_STB || op_q == OP_LDB ||
                    op_q == OP_ALLC;
    status.cnt_last = mword ? (mcnt == 2'd3) : (mcnt == 2'd0);
    status.push_ok = {1'b0, sp} >= ({1'b0, sl} + sz33);
    status.pop_ok = ({1'b0, sp} + sz33) <= {1'b0, sb};
    status.sp_ok = sp >= sl && sp <= sb;
    status.heap_full = hp >= sp;
    status.dest_is_sp = d_q == 8'(R_SP);
    status.sp_chk = !(op_q == OP_AND || op_q == OP_OR || op_q == OP_CMP || op_q == OP_CMPI);
    status.is_call = op_q == OP_CALL;
    status.is_alci = op_q == OP_ALCI;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        rf[i] <= '0;
      end
      code_end <= '0;
    end else begin
      if (cfg_we) begin
        code_end <= cfg_data;
      end
      unique case (cmd.op)
        DP_INIT: begin
          for (int i = 0; i < NUM_REGS; i++) begin
            rf[i] <= '0;
          end
          rf[R_SL] <= {16'd0, code_end} + 32'd1;
          rf[R_HP] <= {16'd0, code_end} + 32'd1;
          rf[R_SB] <= 32'(MEM_BYTES);
          rf[R_SP] <= 32'(MEM_BYTES);
        end
        DP_PC_INC: rf[R_PC] <= rf[R_PC] + 32'd8;
        DP_JUMP: rf[R_PC] <= (op_q == OP_JMR) ? rd_v : imm_q;
        DP_WR_DEST: rf[d_q[REG_AW-1:0]] <= res;
        DP_POP: rf[d_q[REG_AW-1:0]] <= mdata;
        DP_SP_DEC: rf[R_SP] <= sp - sz32;
        DP_SP_INC: rf[R_SP] <= sp + sz32;
        DP_RET: begin
          rf[R_PC] <= mdata;
          rf[R_SP] <= sp + 32'd4;
        end
        DP_ALLOC_LINK: rf[d_q[REG_AW-1:0]] <= hp;
        DP_ALLOC_BUMP: rf[R_HP] <= hp + res;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == DP_PRELOAD) begin
      mem[imm_q[MEM_AW-1:0]] <= pd_q;
    end else if (cmd.op == DP_MEM_WR) begin
      mem[byte_addr] <= mdata[8*mcnt +: 8];
    end
    if (cmd.op == DP_MEM_RA) begin
      mem_q <= mem[byte_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fault_we) begin
      fault_q <= cmd.fault_val;
    end
    unique case (cmd.op)
      DP_LOAD: begin
        op_q <= operation;
        d_q <= dest_reg;
        a_q <= src_reg_a;
        b_q <= src_reg_b;
        imm_q <= immediate;
        pd_q <= preload_data;
        fault_q <= F_OK;
        wv_q <= '0;
        trap_q <= 1'b0;
      end
      DP_RD_D: rd_v <= (d_q < 8'(NUM_REGS)) ? rf[d_q[REG_AW-1:0]] : '0;
      DP_RD_A: ra_v <= (a_q < 8'(NUM_REGS)) ? rf[a_q[REG_AW-1:0]] : '0;
      DP_RD_B: rb_v <= (b_q < 8'(NUM_REGS)) ? rf[b_q[REG_AW-1:0]] : '0;
      DP_ALU: begin
        unique case (op_q)
          OP_MOV: res <= ra_v;
          OP_ADD: res <= ra_v + rb_v;
          OP_ADDI: res <= ra_v + imm_q;
          OP_SUB: res <= ra_v - rb_v;
          OP_SUBI: res <= ra_v - imm_q;
          OP_MUL, OP_MULI: res <= ra_v * mul_b;
          OP_AND: res <= {31'd0, ra_v != 32'd0 && rb_v != 32'd0};
          OP_OR: res <= {31'd0, ra_v != 32'd0 || rb_v != 32'd0};
          OP_CMP: res <= cmp3(ra_v, rb_v);
          OP_CMPI: res <= cmp3(ra_v, imm_q);
          default: res <= imm_q;
        endcase
      end
      DP_WR_DEST: wv_q <= res;
      DP_DIV_START: begin
        rem <= '0;
        dcnt <= '0;
        quo <= (div_signed && div_a[31]) ? -div_a : div_a;
        dvs <= (div_signed && div_b[31]) ? -div_b : div_b;
        dneg <= div_signed && (div_a[31] ^ div_b[31]);
      end
      DP_DIV_STEP: begin
        dcnt <= dcnt + 5'd1;
        if (rem_shift >= {1'b0, dvs}) begin
          rem <= 32'(rem_shift - {1'b0, dvs});
          quo <= {quo[30:0], 1'b1};
        end else begin
          rem <= rem_shift[31:0];
          quo <= {quo[30:0], 1'b0};
        end
      end
      DP_DIV_RES: res <= dneg ? -quo : quo;
      DP_MEM_SETUP: begin
        maddr <= mem_addr_sel;
        mword <= word_sel;
        mcnt <= '0;
        mdata <= status.mem_write ? mem_wdata : '0;
      end
      DP_MEM_WR: mcnt <= mcnt + 2'd1;
      DP_MEM_RD: begin
        mdata[8*mcnt +: 8] <= mem_q;
        mcnt <= mcnt + 2'd1;
      end
      DP_MEM_RES: res <= mdata;
      DP_POP: wv_q <= mdata;
      DP_ALLOC_IMM: res <= imm_q;
      DP_ALLOC_LINK: wv_q <= hp;
      DP_TRAP: trap_q <= 1'b1;
      DP_FINISH: begin
        fault <= fault_q;
        next_pc <= rf[R_PC];
        trap_request <= trap_q;
        trap_code <= trap_q ? imm_q : '0;
        written_value <= wv_q;
      end
      default: ;
    endcase
  end

endmodule

### rtl/core/tvmeu_ctrl.sv
// Controller state machine that sequences each instruction through the datapath.
module tvmeu_ctrl import tvmeu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state, state_next;
  logic   out_valid_next, fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '{op: DP_NONE, fault_we: 1'b0, fault_val: F_OK};
    fin = 1'b0;
    in_stall = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = DP_LOAD;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        state_next = S_FINISH;
        priority if (status.cls == CL_INIT) begin
          cmd.op = DP_INIT;
        end else if (status.cls == CL_PRELOAD) begin
          if (status.preload_ok) begin
            cmd.op = DP_PRELOAD;
          end else begin
            cmd.fault_we = 1'b1;
            cmd.fault_val = F_RANGE;
          end
        end else if (status.pre_fault != F_OK) begin
          cmd.fault_we = 1'b1;
          cmd.fault_val = status.pre_fault;
        end else begin
          cmd.op = DP_PC_INC;
          state_next = S_RD_D;
        end
      end
      S_RD_D: begin
        cmd.op = DP_RD_D;
        state_next = S_RD_A;
      end
      S_RD_A: begin
        cmd.op = DP_RD_A;
        state_next = S_RD_B;
      end
      S_RD_B: begin
        cmd.op = DP_RD_B;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = S_FINISH;
        unique case (status.cls)
          CL_JUMP: cmd.op = DP_JUMP;
          CL_BRANCH: cmd.op = status.taken ? DP_JUMP : DP_NONE;
          CL_ALU: begin
            cmd.op = DP_ALU;
            state_next = S_WB;
          end
          CL_DIV: begin
            if (status.div_zero) begin
              cmd.fault_we = 1'b1;
              cmd.fault_val = F_DIVZERO;
            end else begin
              cmd.op = DP_DIV_START;
              state_next = S_DIV;
            end
          end
          CL_LOAD, CL_STORE: begin
            cmd.op = DP_MEM_SETUP;
            state_next = S_MEM_GO;
          end
          CL_ALLOC: begin
            if (status.is_alci) begin
              cmd.op = DP_ALLOC_IMM;
              state_next = S_ALLOC;
            end else begin
              cmd.op = DP_MEM_SETUP;
              state_next = S_MEM_GO;
            end
          end
          CL_PUSH: begin
            if (status.push_ok) begin
              cmd.op = DP_SP_DEC;
              state_next = S_PUSH_CHK;
            end else begin
              cmd.fault_we = 1'b1;
              cmd.fault_val = F_STACK;
            end
          end
          CL_POP, CL_RET: begin
            if (status.pop_ok) begin
              cmd.op = DP_MEM_SETUP;
              state_next = S_MEM_GO;
            end else begin
              cmd.fault_we = 1'b1;
              cmd.fault_val = F_STACK;
            end
          end
          CL_TRAP: cmd.op = DP_TRAP;
          default: ;
        endcase
      end
      S_WB: begin
        cmd.op = DP_WR_DEST;
        state_next = S_WB_CHK;
      end
      S_WB_CHK: begin
        state_next = S_FINISH;
        if (status.sp_chk && status.dest_is_sp && !status.sp_ok) begin
          cmd.fault_we = 1'b1;
          cmd.fault_val = F_STACK;
        end
      end
      S_DIV: begin
        cmd.op = DP_DIV_STEP;
        if (status.div_last) begin
          state_next = S_DIV_END;
        end
      end
      S_DIV_END: begin
        cmd.op = DP_DIV_RES;
        state_next = S_WB;
      end
      S_PUSH_CHK: begin
        if (!status.is_call && status.dest_is_sp && !status.sp_ok) begin
          cmd.fault_we = 1'b1;
          cmd.fault_val = F_STACK;
          state_next = S_FINISH;
        end else begin
          cmd.op = DP_MEM_SETUP;
          state_next = S_MEM_GO;
        end
      end
      S_MEM_GO: begin
        priority if (!status.mem_ok && (status.direct || status.cls == CL_ALLOC)) begin
          cmd.fault_we = 1'b1;
          cmd.fault_val = F_RANGE;
          state_next = S_FINISH;
        end else if (!status.mem_ok) begin
          state_next = S_MEM_POST;
        end else if (status.mem_write) begin
          state_next = S_MEM_WR;
        end else begin
          state_next = S_MEM_RA;
        end
      end
      S_MEM_WR: begin
        cmd.op = DP_MEM_WR;
        if (status.cnt_last) begin
          state_next = S_MEM_POST;
        end
      end
      S_MEM_RA: begin
        cmd.op = DP_MEM_RA;
        state_next = S_MEM_RD;
      end
      S_MEM_RD: begin
        cmd.op = DP_MEM_RD;
        state_next = status.cnt_last ? S_MEM_POST : S_MEM_RA;
      end
      S_MEM_POST: begin
        state_next = S_FINISH;
        unique case (status.cls)
          CL_LOAD: begin
            cmd.op = DP_MEM_RES;
            state_next = S_WB;
          end
          CL_ALLOC: begin
            cmd.op = DP_MEM_RES;
            state_next = S_ALLOC;
          end
          CL_PUSH: cmd.op = status.is_call ? DP_JUMP : DP_NONE;
          CL_POP: begin
            cmd.op = DP_POP;
            state_next = S_POP_SP;
          end
          CL_RET: begin
            cmd.op = DP_RET;
            state_next = S_RET_CHK;
          end
          default: ;
        endcase
      end
      S_POP_SP: begin
        cmd.op = DP_SP_INC;
        state_next = S_POP_CHK;
      end
      S_POP_CHK: begin
        state_next = S_FINISH;
        if (!status.sp_ok) begin
          cmd.fault_we = 1'b1;
          cmd.fault_val = F_STACK;
        end
      end
      S_RET_CHK: begin
        state_next = S_FINISH;
        if (status.dest_is_sp && !status.sp_ok) begin
          cmd.fault_we = 1'b1;
          cmd.fault_val = F_STACK;
        end
      end
      S_ALLOC: begin
        cmd.op = DP_ALLOC_LINK;
        state_next = S_ALLOC_BUMP;
      end
      S_ALLOC_BUMP: begin
        cmd.op = DP_ALLOC_BUMP;
        state_next = S_ALLOC_CHK;
      end
      S_ALLOC_CHK: begin
        state_next = S_FINISH;
        if (status.heap_full) begin
          cmd.fault_we = 1'b1;
          cmd.fault_val = F_HEAP;
        end
      end
      S_FINISH: begin
        if (!out_valid || !out_stall) begin
          cmd.op = DP_FINISH;
          fin = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    if (fin) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  // An accepted transaction always begins with the operand check.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_CHECK))
    else $error("accepted transaction did not enter the check state");

  // A result still waiting at the output is never overwritten or lost.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("pending result dropped while stalled");

  // The divider leaves its loop exactly after its last step.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && status.div_last) |=> (state == S_DIV_END))
    else $error("divider loop did not terminate");

  // The result register is only loaded when the output side can take it.
  assert property (@(posedge clk) disable iff (rst)
    (cmd.op == DP_FINISH) |-> (!out_valid || !out_stall))
    else $error("result loaded over a stalled transaction");

endmodule
